### rtl/wtcm_pkg.sv
// shared constants, widths and codes of the wire triple coincidence matcher
package wtcm_pkg;

  // geometry
  localparam int NumWires      = 4096;
  localparam int NumEntries    = 16384;
  localparam int NumBoundaries = 4;
  localparam int NumColumns    = 4096;
  localparam int Planes        = 3;
  localparam int PairVotes     = 2;

  // field widths
  localparam int ActionW = 3;
  localparam int BndW    = 2;
  localparam int IdxW    = 14;
  localparam int WireW   = 12;
  localparam int PlaneW  = 2;
  localparam int VoteW   = 2;
  localparam int CfgW    = 7;
  localparam int CfgIdxW = 1;

  // derived sizes
  localparam int TabDepth = NumBoundaries * NumEntries;
  localparam int TabAw    = $clog2(TabDepth);
  localparam int TabW     = Planes * WireW;
  localparam int HitAw    = $clog2(NumWires);
  localparam int BadAw    = $clog2(NumColumns);
  localparam int SweepLen = (NumWires > NumColumns) ? NumWires : NumColumns;
  localparam int SwAw     = $clog2(SweepLen);
  localparam int RemW     = CfgW + 1;
  localparam int DivCntW  = $clog2(WireW);

  // action codes
  localparam logic [ActionW-1:0] ActLoad  = 3'd0;
  localparam logic [ActionW-1:0] ActHit   = 3'd1;
  localparam logic [ActionW-1:0] ActBad   = 3'd2;
  localparam logic [ActionW-1:0] ActClear = 3'd3;
  localparam logic [ActionW-1:0] ActQuery = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgUseBad     = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDownsample = 1'd1;

  // missing plane code when all planes are hit
  localparam logic [PlaneW-1:0] MissNone = 2'd3;

endpackage

### rtl/wtcm_ram.sv
// generic single write port, single read port ram with registered read
module wtcm_ram #(
  parameter int Width = 1,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/wire_triple_coincidence_match_top.sv
// wire triple coincidence matcher: triple tables, hit and bad-column maps, query logic
//
// usage
// - a command word is taken at a rising edge with start_i high and busy_o low
// - action load writes a (u, v, y) triple into the table of one boundary
// - set hit / set bad column write one bit of a plane's hit or bad-column map
// - load, set hit and set bad column keep busy_o low
// - clear hits sweeps the three hit maps, one wire a cycle, with busy_o high
// - a query reads the triple (table ram), then the three hit maps in parallel
//   (one ram per plane), counts the votes and registers the result word, which
//   strobes out_strobe_o; busy_o is high through the table and vote states
// - a two-plane vote with bad channels enabled runs the missing wire through a
//   one-bit-a-cycle restoring divider and one bad-map read (divide, column
//   and check states) before the result word is registered
// - out_strobe_o marks each result word for one cycle only; the receiver
//   cannot stall, so nothing is ever held back
// - config writes (cfg_we_i) take effect at once and are meant for idle time
// - after reset the block clears hit and bad-column maps, one entry a cycle,
//   over max(NumWires, NumColumns) entries with busy_o high
// - table entries are undefined until loaded
module wire_triple_coincidence_match_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          cfg_we_i,
  input  logic [wtcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wtcm_pkg::CfgW-1:0]     cfg_wdata_i,
  // command word
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [wtcm_pkg::ActionW-1:0]  action_i,
  input  logic [wtcm_pkg::BndW-1:0]     boundary_i,
  input  logic [wtcm_pkg::IdxW-1:0]     combo_index_i,
  input  logic [wtcm_pkg::WireW-1:0]    u_wire_i,
  input  logic [wtcm_pkg::WireW-1:0]    v_wire_i,
  input  logic [wtcm_pkg::WireW-1:0]    y_wire_i,
  input  logic [wtcm_pkg::PlaneW-1:0]   plane_i,
  input  logic [wtcm_pkg::WireW-1:0]    wire_or_column_i,
  input  logic                          flag_i,
  // result word
  output logic                          out_strobe_o,
  output logic [wtcm_pkg::IdxW-1:0]     entry_echo_o,
  output logic [wtcm_pkg::BndW-1:0]     boundary_echo_o,
  output logic                          matched_o,
  output logic                          via_bad_channel_o,
  output logic [wtcm_pkg::VoteW-1:0]    vote_count_o,
  output logic [wtcm_pkg::PlaneW-1:0]   missing_plane_o
);

  localparam int StW = 3;
  localparam logic [StW-1:0] StIdle = 3'd0;  // taking command words
  localparam logic [StW-1:0] StTab  = 3'd1;  // table data out, hit reads issued
  localparam logic [StW-1:0] StVote = 3'd2;  // hit data out, count votes
  localparam logic [StW-1:0] StDiv  = 3'd3;  // divide missing wire
  localparam logic [StW-1:0] StCol  = 3'd4;  // bad-map read issued
  localparam logic [StW-1:0] StChk  = 3'd5;  // bad data out
  localparam logic [StW-1:0] StClr  = 3'd6;  // clearing sweep

  localparam int Planes = wtcm_pkg::Planes;
  localparam int WireW  = wtcm_pkg::WireW;
  localparam int HitAw  = wtcm_pkg::HitAw;
  localparam int BadAw  = wtcm_pkg::BadAw;
  localparam int RemW   = wtcm_pkg::RemW;

  // config registers
  logic                      use_bad_q;
  logic [wtcm_pkg::CfgW-1:0] ds_q;
  logic [wtcm_pkg::CfgW-1:0] ds_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_bad_q <= 1'b0;
      ds_q      <= wtcm_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wtcm_pkg::CfgUseBad:     use_bad_q <= cfg_wdata_i[0];
        wtcm_pkg::CfgDownsample: ds_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a zero factor acts as one
  assign ds_eff = (ds_q == '0) ? wtcm_pkg::CfgW'(1) : ds_q;

  // control state
  logic [StW-1:0]              state_q, state_d;
  logic [wtcm_pkg::SwAw-1:0]   cnt_q, cnt_d;
  logic                        clr_bad_q, clr_bad_d;
  logic                        strobe_q, strobe_d;

  // payload state
  logic [wtcm_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [wtcm_pkg::BndW-1:0]   bnd_q, bnd_d;
  logic [WireW-1:0]            wire_q [Planes];
  logic [Planes-1:0]           wire_ok_q;
  logic [wtcm_pkg::VoteW-1:0]  vote_q, vote_d;
  logic [wtcm_pkg::PlaneW-1:0] miss_q, miss_d;
  logic [WireW-1:0]            num_q, num_d;
  logic [RemW-1:0]             rem_q, rem_d;
  logic [WireW-1:0]            quo_q, quo_d;
  logic [wtcm_pkg::DivCntW-1:0] dcnt_q, dcnt_d;
  logic                        col_ok_q;
  logic                        o_matched_q, o_matched_d;
  logic                        o_via_q, o_via_d;
  logic [wtcm_pkg::VoteW-1:0]  o_vote_q, o_vote_d;
  logic [wtcm_pkg::PlaneW-1:0] o_miss_q, o_miss_d;
  logic [wtcm_pkg::IdxW-1:0]   o_idx_q, o_idx_d;
  logic [wtcm_pkg::BndW-1:0]   o_bnd_q, o_bnd_d;

  logic accept;
  logic in_table;
  logic sweeping;
  logic sweep_last;

  assign busy_o   = (state_q != StIdle);
  assign accept   = start_i && !busy_o;
  assign sweeping = (state_q == StClr);
  assign in_table = (32'(boundary_i) < 32'(wtcm_pkg::NumBoundaries)) &&
                    (32'(combo_index_i) < 32'(wtcm_pkg::NumEntries));
  assign sweep_last = clr_bad_q ? (32'(cnt_q) == 32'(wtcm_pkg::SweepLen - 1))
                                : (32'(cnt_q) == 32'(wtcm_pkg::NumWires - 1));

  // triple table, one ram holding u, v, y side by side
  logic                    tab_we, tab_re;
  logic [wtcm_pkg::TabAw-1:0] tab_addr;
  logic [wtcm_pkg::TabW-1:0]  tab_wdata, tab_rdata;
  logic [WireW-1:0]        tab_wire [Planes];

  assign tab_addr  = wtcm_pkg::TabAw'(32'(boundary_i) * wtcm_pkg::NumEntries +
                                      32'(combo_index_i));
  assign tab_wdata = {u_wire_i, v_wire_i, y_wire_i};
  assign tab_we    = accept && (action_i == wtcm_pkg::ActLoad) && in_table;
  assign tab_re    = accept && (action_i == wtcm_pkg::ActQuery) && in_table;

  wtcm_ram #(
    .Width(wtcm_pkg::TabW),
    .Depth(wtcm_pkg::TabDepth)
  ) u_tab_ram (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(tab_addr),
    .wdata_i(tab_wdata),
    .re_i   (tab_re),
    .raddr_i(tab_addr),
    .rdata_o(tab_rdata)
  );

  // per-plane hit and bad-column maps
  logic [Planes-1:0] hit_we, hit_rdata;
  logic [Planes-1:0] bad_we, bad_rdata;
  logic [HitAw-1:0]  hit_waddr;
  logic [BadAw-1:0]  bad_waddr, bad_raddr;
  logic              hit_wdata, bad_wdata;
  logic              hit_in_range, bad_in_range;

  assign hit_in_range = 32'(wire_or_column_i) < 32'(wtcm_pkg::NumWires);
  assign bad_in_range = 32'(wire_or_column_i) < 32'(wtcm_pkg::NumColumns);
  assign hit_waddr = sweeping ? HitAw'(cnt_q) : HitAw'(wire_or_column_i);
  assign bad_waddr = sweeping ? BadAw'(cnt_q) : BadAw'(wire_or_column_i);
  assign hit_wdata = sweeping ? 1'b0 : flag_i;
  assign bad_wdata = sweeping ? 1'b0 : flag_i;
  assign bad_raddr = BadAw'(quo_q);

  for (genvar p = 0; p < Planes; p++) begin : g_plane
    logic [HitAw-1:0] hit_raddr;

    assign tab_wire[p] = tab_rdata[(Planes - 1 - p) * WireW +: WireW];
    assign hit_raddr   = HitAw'(tab_wire[p]);

    assign hit_we[p] = (sweeping && (32'(cnt_q) < 32'(wtcm_pkg::NumWires))) ||
                       (accept && (action_i == wtcm_pkg::ActHit) &&
                        (plane_i == wtcm_pkg::PlaneW'(p)) && hit_in_range);
    assign bad_we[p] = (sweeping && clr_bad_q &&
                        (32'(cnt_q) < 32'(wtcm_pkg::NumColumns))) ||
                       (accept && (action_i == wtcm_pkg::ActBad) &&
                        (plane_i == wtcm_pkg::PlaneW'(p)) && bad_in_range);

    wtcm_ram #(
      .Width(1),
      .Depth(wtcm_pkg::NumWires)
    ) u_hit_ram (
      .clk_i  (clk_i),
      .we_i   (hit_we[p]),
      .waddr_i(hit_waddr),
      .wdata_i(hit_wdata),
      .re_i   (state_q == StTab),
      .raddr_i(hit_raddr),
      .rdata_o(hit_rdata[p])
    );

    wtcm_ram #(
      .Width(1),
      .Depth(wtcm_pkg::NumColumns)
    ) u_bad_ram (
      .clk_i  (clk_i),
      .we_i   (bad_we[p]),
      .waddr_i(bad_waddr),
      .wdata_i(bad_wdata),
      .re_i   (state_q == StCol),
      .raddr_i(bad_raddr),
      .rdata_o(bad_rdata[p])
    );
  end

  // vote count and first unhit plane
  logic [Planes-1:0]           hit_ok;
  logic [wtcm_pkg::VoteW-1:0]  vote_sum;
  logic [wtcm_pkg::PlaneW-1:0] first_miss;

  assign hit_ok = hit_rdata & wire_ok_q;

  always_comb begin
    vote_sum   = '0;
    first_miss = wtcm_pkg::MissNone;
    for (int p = 0; p < Planes; p++) begin
      vote_sum = vote_sum + wtcm_pkg::VoteW'(hit_ok[p]);
      if (!hit_ok[p] && (first_miss == wtcm_pkg::MissNone)) begin
        first_miss = wtcm_pkg::PlaneW'(p);
      end
    end
  end

  // restoring divider step, one quotient bit a cycle
  logic [RemW-1:0] rem_sh;
  logic            rem_ge;

  assign rem_sh = {rem_q[RemW-2:0], num_q[WireW-1]};
  assign rem_ge = rem_sh >= {1'b0, ds_eff};

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_bad_d   = clr_bad_q;
    strobe_d    = 1'b0;
    idx_d       = idx_q;
    bnd_d       = bnd_q;
    vote_d      = vote_q;
    miss_d      = miss_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    o_matched_d = o_matched_q;
    o_via_d     = o_via_q;
    o_vote_d    = o_vote_q;
    o_miss_d    = o_miss_q;
    o_idx_d     = o_idx_q;
    o_bnd_d     = o_bnd_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (action_i)
            wtcm_pkg::ActClear: begin
              state_d   = StClr;
              cnt_d     = '0;
              clr_bad_d = 1'b0;
            end
            wtcm_pkg::ActQuery: begin
              idx_d = combo_index_i;
              bnd_d = boundary_i;
              if (in_table) begin
                state_d = StTab;
              end
            end
            default: ;
          endcase
        end
      end
      StTab: begin
        state_d = StVote;
      end
      StVote: begin
        vote_d = vote_sum;
        miss_d = first_miss;
        if ((vote_sum == wtcm_pkg::VoteW'(wtcm_pkg::PairVotes)) && use_bad_q) begin
          // two planes hit: divide the missing wire down to a column
          state_d = StDiv;
          num_d   = wire_q[first_miss];
          rem_d   = '0;
          quo_d   = '0;
          dcnt_d  = wtcm_pkg::DivCntW'(WireW - 1);
        end else begin
          state_d     = StIdle;
          strobe_d    = 1'b1;
          o_matched_d = (vote_sum == wtcm_pkg::VoteW'(Planes));
          o_via_d     = 1'b0;
          o_vote_d    = vote_sum;
          o_miss_d    = first_miss;
          o_idx_d     = idx_q;
          o_bnd_d     = bnd_q;
        end
      end
      StDiv: begin
        num_d = {num_q[WireW-2:0], 1'b0};
        rem_d = rem_ge ? (rem_sh - {1'b0, ds_eff}) : rem_sh;
        quo_d = {quo_q[WireW-2:0], rem_ge};
        if (dcnt_q == '0) begin
          state_d = StCol;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      StCol: begin
        state_d = StChk;
      end
      StChk: begin
        state_d     = StIdle;
        strobe_d    = 1'b1;
        o_matched_d = bad_rdata[miss_q] && col_ok_q;
        o_via_d     = bad_rdata[miss_q] && col_ok_q;
        o_vote_d    = vote_q;
        o_miss_d    = miss_q;
        o_idx_d     = idx_q;
        o_bnd_d     = bnd_q;
      end
      StClr: begin
        if (sweep_last) begin
          state_d = StIdle;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers: reset starts the clearing sweep of both map kinds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClr;
      cnt_q     <= '0;
      clr_bad_q <= 1'b1;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clr_bad_q <= clr_bad_d;
      strobe_q  <= strobe_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    bnd_q       <= bnd_d;
    vote_q      <= vote_d;
    miss_q      <= miss_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dcnt_q      <= dcnt_d;
    o_matched_q <= o_matched_d;
    o_via_q     <= o_via_d;
    o_vote_q    <= o_vote_d;
    o_miss_q    <= o_miss_d;
    o_idx_q     <= o_idx_d;
    o_bnd_q     <= o_bnd_d;
    // column range check rides along with the bad-map read
    if (state_q == StCol) begin
      col_ok_q <= 32'(quo_q) < 32'(wtcm_pkg::NumColumns);
    end
    // table wires and their range flags, captured while hit reads go out
    if (state_q == StTab) begin
      for (int p = 0; p < Planes; p++) begin
        wire_q[p]    <= tab_wire[p];
        wire_ok_q[p] <= 32'(tab_wire[p]) < 32'(wtcm_pkg::NumWires);
      end
    end
  end

  assign out_strobe_o      = strobe_q;
  assign entry_echo_o      = o_idx_q;
  assign boundary_echo_o   = o_bnd_q;
  assign matched_o         = o_matched_q;
  assign via_bad_channel_o = o_via_q;
  assign vote_count_o      = o_vote_q;
  assign missing_plane_o   = o_miss_q;

endmodule

### tb/wtcm_match_checker.sv
// checker of the coincidence matcher: follows commands and config, predicts and compares results
module wtcm_match_checker
  import wtcm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [BndW-1:0]    boundary_i,
  input  logic [IdxW-1:0]    combo_index_i,
  input  logic [WireW-1:0]   u_wire_i,
  input  logic [WireW-1:0]   v_wire_i,
  input  logic [WireW-1:0]   y_wire_i,
  input  logic [PlaneW-1:0]  plane_i,
  input  logic [WireW-1:0]   wire_or_column_i,
  input  logic               flag_i,
  input  logic               out_strobe_o,
  input  logic [IdxW-1:0]    entry_echo_o,
  input  logic [BndW-1:0]    boundary_echo_o,
  input  logic               matched_o,
  input  logic               via_bad_channel_o,
  input  logic [VoteW-1:0]   vote_count_o,
  input  logic [PlaneW-1:0]  missing_plane_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [IdxW-1:0]   entry;
    logic [BndW-1:0]   bnd;
    logic              matched;
    logic              via_bad;
    logic [VoteW-1:0]  votes;
    logic [PlaneW-1:0] missing;
  } coinc_word_t;

  // triples packed as {y, v, u}, so plane p sits at [p]
  logic [Planes-1:0][WireW-1:0] triple_tab [int];
  logic [NumWires-1:0]          hit_map [Planes];
  logic [NumColumns-1:0]        bad_map [Planes];
  logic                         use_bad;
  logic [CfgW-1:0]              ds_reg;
  coinc_word_t                  awaited_words [$];

  function automatic coinc_word_t coincidence_of(input logic [BndW-1:0] bnd,
                                                 input logic [IdxW-1:0] idx);
    logic [Planes-1:0][WireW-1:0] w;
    int                           votes;
    int                           miss;
    int                           div;
    int                           col;
    coinc_word_t                  r;
    w     = triple_tab[int'(bnd) * NumEntries + int'(idx)];
    votes = 0;
    miss  = int'(MissNone);
    for (int p = 0; p < Planes; p++) begin
      if (int'(w[p]) < NumWires && hit_map[p][w[p]] === 1'b1) votes++;
      else if (miss == int'(MissNone)) miss = p;
    end
    r.entry   = idx;
    r.bnd     = bnd;
    r.matched = 1'b0;
    r.via_bad = 1'b0;
    r.votes   = VoteW'(votes);
    r.missing = PlaneW'(miss);
    if (votes >= Planes) begin
      r.matched = 1'b1;
    end else if (votes == PairVotes && use_bad) begin
      // a zero factor counts as one
      div = (ds_reg == '0) ? 1 : int'(ds_reg);
      col = int'(w[miss]) / div;
      if (col < NumColumns && bad_map[miss][col] === 1'b1) begin
        r.matched = 1'b1;
        r.via_bad = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [IdxW-1:0] want,
                               input logic [IdxW-1:0] got, inout bit wrong);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      wrong = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    coinc_word_t want;
    bit          wrong;
    if (!rst_ni) begin
      triple_tab.delete();
      for (int p = 0; p < Planes; p++) begin
        hit_map[p] = '0;
        bad_map[p] = '0;
      end
      use_bad = 1'b0;
      ds_reg  = CfgW'(1);
      awaited_words.delete();
      fail_count_o = 0;
    end else begin
      if (out_strobe_o === 1'b1) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: result word for entry %0d with nothing awaited, expected none",
                   $time, entry_echo_o);
          fail_count_o++;
        end else begin
          want  = awaited_words.pop_front();
          wrong = 1'b0;
          compare_field("entry_echo", want.entry, entry_echo_o, wrong);
          compare_field("boundary_echo", want.bnd, boundary_echo_o, wrong);
          compare_field("matched", want.matched, matched_o, wrong);
          compare_field("via_bad_channel", want.via_bad, via_bad_channel_o, wrong);
          compare_field("vote_count", want.votes, vote_count_o, wrong);
          compare_field("missing_plane", want.missing, missing_plane_o, wrong);
          if (wrong) fail_count_o++;
        end
      end
      if (cfg_we_i === 1'b1) begin
        if (cfg_idx_i == CfgUseBad) use_bad = cfg_wdata_i[0];
        else if (cfg_idx_i == CfgDownsample) ds_reg = cfg_wdata_i;
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        // boundary and index always fit the tables at these widths
        case (action_i)
          ActLoad: begin
            triple_tab[int'(boundary_i) * NumEntries + int'(combo_index_i)] =
              {y_wire_i, v_wire_i, u_wire_i};
          end
          ActHit: begin
            if (plane_i < Planes) hit_map[plane_i][wire_or_column_i] = flag_i;
          end
          ActBad: begin
            if (plane_i < Planes) bad_map[plane_i][wire_or_column_i] = flag_i;
          end
          ActClear: begin
            for (int p = 0; p < Planes; p++) hit_map[p] = '0;
          end
          ActQuery: begin
            awaited_words.insert(awaited_words.size(),
                                 coincidence_of(boundary_i, combo_index_i));
          end
          default: ;
        endcase
      end
    end
    pending_o = awaited_words.size();
  end

endmodule

### tb/wire_triple_coincidence_match_top_tb.sv
// testbench top of the coincidence matcher: command stimulus, config phases and verdict
module wire_triple_coincidence_match_top_tb;
  import wtcm_pkg::*;

  // unused action codes, the block must ignore them
  localparam logic [ActionW-1:0] ActSpareLo = 3'd5;
  localparam logic [ActionW-1:0] ActSpareHi = 3'd7;

  localparam int NumPhases    = 6;
  localparam int PhaseItems   = 100;
  // a bit more than the slow bad-channel query path
  localparam int SettleCycles = 24;
  // covers the reset clear, every hit clear and the slowest query many times over
  localparam int TimeLimit    = 50000000;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [BndW-1:0]    bnd;
    logic [IdxW-1:0]    idx;
    logic [WireW-1:0]   u;
    logic [WireW-1:0]   v;
    logic [WireW-1:0]   y;
    logic [PlaneW-1:0]  plane;
    logic [WireW-1:0]   woc;
    logic               flag;
  } cmd_word_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i        = '0;
  logic [CfgW-1:0]    cfg_wdata_i      = '0;
  logic               start_i          = 1'b0;
  logic [ActionW-1:0] action_i         = '0;
  logic [BndW-1:0]    boundary_i       = '0;
  logic [IdxW-1:0]    combo_index_i    = '0;
  logic [WireW-1:0]   u_wire_i         = '0;
  logic [WireW-1:0]   v_wire_i         = '0;
  logic [WireW-1:0]   y_wire_i         = '0;
  logic [PlaneW-1:0]  plane_i          = '0;
  logic [WireW-1:0]   wire_or_column_i = '0;
  logic               flag_i           = 1'b0;
  logic               busy_o;
  logic               out_strobe_o;
  logic [IdxW-1:0]    entry_echo_o;
  logic [BndW-1:0]    boundary_echo_o;
  logic               matched_o;
  logic               via_bad_channel_o;
  logic [VoteW-1:0]   vote_count_o;
  logic [PlaneW-1:0]  missing_plane_o;

  int fail_count;
  int pending_count;

  // stimulus bookkeeping
  int                      idle_pct   = 0;
  int                      words_sent = 0;
  logic [CfgW-1:0]         cur_ds     = CfgW'(1);
  // entries that have been loaded, so a query never reads an unwritten one
  bit                      loaded_map [logic [BndW+IdxW-1:0]];
  logic [BndW+IdxW-1:0]    loaded_keys [$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  wire_triple_coincidence_match_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .boundary_i       (boundary_i),
    .combo_index_i    (combo_index_i),
    .u_wire_i         (u_wire_i),
    .v_wire_i         (v_wire_i),
    .y_wire_i         (y_wire_i),
    .plane_i          (plane_i),
    .wire_or_column_i (wire_or_column_i),
    .flag_i           (flag_i),
    .out_strobe_o     (out_strobe_o),
    .entry_echo_o     (entry_echo_o),
    .boundary_echo_o  (boundary_echo_o),
    .matched_o        (matched_o),
    .via_bad_channel_o(via_bad_channel_o),
    .vote_count_o     (vote_count_o),
    .missing_plane_o  (missing_plane_o)
  );

  wtcm_match_checker coinc_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .boundary_i       (boundary_i),
    .combo_index_i    (combo_index_i),
    .u_wire_i         (u_wire_i),
    .v_wire_i         (v_wire_i),
    .y_wire_i         (y_wire_i),
    .plane_i          (plane_i),
    .wire_or_column_i (wire_or_column_i),
    .flag_i           (flag_i),
    .out_strobe_o     (out_strobe_o),
    .entry_echo_o     (entry_echo_o),
    .boundary_echo_o  (boundary_echo_o),
    .matched_o        (matched_o),
    .via_bad_channel_o(via_bad_channel_o),
    .vote_count_o     (vote_count_o),
    .missing_plane_o  (missing_plane_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending_count)
  );

  // every field random, so fields a command does not use still toggle
  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    w.action = ActionW'($urandom);
    w.bnd    = BndW'($urandom);
    w.idx    = IdxW'($urandom);
    w.u      = WireW'($urandom);
    w.v      = WireW'($urandom);
    w.y      = WireW'($urandom);
    w.plane  = PlaneW'($urandom);
    w.woc    = WireW'($urandom);
    w.flag   = 1'($urandom);
    return w;
  endfunction

  // wire index with a bias toward the two ends of the plane
  function automatic logic [WireW-1:0] wire_pick();
    if ($urandom_range(7) == 0) return ($urandom_range(1) == 0) ? WireW'(0) : WireW'(NumWires-1);
    return WireW'($urandom);
  endfunction

  // one command word; called and returns on a rising edge, start_i stays high after it
  task automatic send_word(input cmd_word_t w);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      // mostly short gaps, now and then long enough to span a slow query
      repeat (($urandom_range(7) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
    start_i          <= 1'b1;
    action_i         <= w.action;
    boundary_i       <= w.bnd;
    combo_index_i    <= w.idx;
    u_wire_i         <= w.u;
    v_wire_i         <= w.v;
    y_wire_i         <= w.y;
    plane_i          <= w.plane;
    wire_or_column_i <= w.woc;
    flag_i           <= w.flag;
    // busy_o read right after the edge is the value that edge saw
    do @(posedge clk_i); while (busy_o !== 1'b0);
    // ignored words do not count toward the item budget
    if (w.action <= ActQuery &&
        !((w.action == ActHit || w.action == ActBad) && w.plane >= Planes))
      words_sent++;
  endtask

  task automatic do_load(input logic [BndW-1:0] b, input logic [IdxW-1:0] i,
                         input logic [WireW-1:0] u, input logic [WireW-1:0] v,
                         input logic [WireW-1:0] y);
    cmd_word_t            w;
    logic [BndW+IdxW-1:0] key;
    w        = rand_word();
    w.action = ActLoad;
    w.bnd    = b;
    w.idx    = i;
    w.u      = u;
    w.v      = v;
    w.y      = y;
    key      = {b, i};
    if (!loaded_map.exists(key)) begin
      loaded_map[key] = 1'b1;
      loaded_keys.insert(loaded_keys.size(), key);
    end
    send_word(w);
  endtask

  task automatic do_hit(input logic [PlaneW-1:0] p, input logic [WireW-1:0] wv,
                        input logic f);
    cmd_word_t w;
    w        = rand_word();
    w.action = ActHit;
    w.plane  = p;
    w.woc    = wv;
    w.flag   = f;
    send_word(w);
  endtask

  task automatic do_bad(input logic [PlaneW-1:0] p, input logic [WireW-1:0] c,
                        input logic f);
    cmd_word_t w;
    w        = rand_word();
    w.action = ActBad;
    w.plane  = p;
    w.woc    = c;
    w.flag   = f;
    send_word(w);
  endtask

  task automatic do_query(input logic [BndW-1:0] b, input logic [IdxW-1:0] i);
    cmd_word_t w;
    w        = rand_word();
    w.action = ActQuery;
    w.bnd    = b;
    w.idx    = i;
    send_word(w);
  endtask

  // clear hits, or an unused action
  task automatic do_other(input logic [ActionW-1:0] a);
    cmd_word_t w;
    w        = rand_word();
    w.action = a;
    send_word(w);
  endtask

  // query some entry loaded at any earlier point
  task automatic do_query_old();
    logic [BndW+IdxW-1:0] key;
    if (loaded_keys.size() == 0) return;
    key = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
    do_query(key[BndW+IdxW-1 -: BndW], key[IdxW-1:0]);
  endtask

  // stray words: random bits including the out of range plane, unused actions, old entries
  task automatic noise_word();
    case ($urandom_range(9))
      0, 1: do_hit(PlaneW'($urandom), WireW'($urandom), 1'($urandom));
      2: do_bad(PlaneW'($urandom), WireW'($urandom), 1'($urandom));
      3: do_other(ActSpareLo + ActionW'($urandom_range(ActSpareHi - ActSpareLo)));
      4: do_load(BndW'($urandom), IdxW'($urandom), wire_pick(), wire_pick(), wire_pick());
      default: do_query_old();
    endcase
  endtask

  // one event: load a few triples, raise hits on all, two, one or no planes of each,
  // mark the missing wire's column bad on some two-plane ones, then query them
  task automatic run_event();
    int                           n;
    int                           pat;
    int                           m;
    int                           ds_eff;
    logic [BndW-1:0]              eb [5];
    logic [IdxW-1:0]              ei [5];
    logic [Planes-1:0][WireW-1:0] ew [5];
    logic [PlaneW+WireW-1:0]      raised_hits [$];
    n      = $urandom_range(1, 5);
    ds_eff = (cur_ds == '0) ? 1 : int'(cur_ds);
    for (int k = 0; k < n; k++) begin
      eb[k] = BndW'($urandom_range(NumBoundaries - 1));
      if ($urandom_range(7) == 0)
        ei[k] = ($urandom_range(1) == 0) ? IdxW'(0) : IdxW'(NumEntries - 1);
      else
        ei[k] = IdxW'($urandom);
      for (int p = 0; p < Planes; p++) ew[k][p] = wire_pick();
      do_load(eb[k], ei[k], ew[k][0], ew[k][1], ew[k][2]);
      if ($urandom_range(5) == 0) noise_word();
    end
    for (int k = 0; k < n; k++) begin
      pat = $urandom_range(9);
      m   = $urandom_range(Planes - 1);
      for (int p = 0; p < Planes; p++) begin
        if (pat <= 3 || (pat <= 7 && p != m) || (pat == 8 && p == m)) begin
          do_hit(PlaneW'(p), ew[k][p], 1'b1);
          raised_hits.insert(raised_hits.size(), {PlaneW'(p), ew[k][p]});
        end
      end
      if (pat >= 4 && pat <= 7 && $urandom_range(1) == 1)
        do_bad(PlaneW'(m), WireW'(int'(ew[k][m]) / ds_eff), 1'b1);
      if ($urandom_range(5) == 0) noise_word();
    end
    for (int k = 0; k < n; k++) begin
      do_query(eb[k], ei[k]);
      if ($urandom_range(5) == 0) noise_word();
    end
    repeat ($urandom_range(2)) do_query_old();
    // wind down: full clear, lower the raised hits one by one, or keep them
    case ($urandom_range(2))
      0: do_other(ActClear);
      1: begin
        foreach (raised_hits[h])
          do_hit(raised_hits[h][PlaneW+WireW-1 -: PlaneW], raised_hits[h][WireW-1:0], 1'b0);
        do_query(eb[0], ei[0]);
      end
      default: ;
    endcase
  endtask

  // wait until every result is in and the block is idle, then a short pause
  task automatic settle();
    start_i <= 1'b0;
    // read at the falling edge, where everything of the rising edge has settled
    do @(negedge clk_i); while (pending_count != 0 || busy_o !== 1'b0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(input bit ub, input logic [CfgW-1:0] ds);
    logic [CfgW-2:0] junk;
    junk = (CfgW-1)'($urandom);
    settle();
    // only bit 0 of the enable write matters, the rest is random filler
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgUseBad;
    cfg_wdata_i <= {junk, ub};
    @(posedge clk_i);
    cfg_idx_i   <= CfgDownsample;
    cfg_wdata_i <= ds;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_ds = ds;
  endtask

  initial begin : stimulus
    bit                 ub;
    logic [CfgW-1:0]    ds;
    int                 target;
    logic [ActionW:0]   a;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset config: bad channels off, factor one
    do_load(BndW'(0), IdxW'(0), WireW'(0), WireW'(0), WireW'(0));
    do_load(BndW'(NumBoundaries - 1), IdxW'(NumEntries - 1), WireW'(NumWires - 1),
            WireW'(NumWires - 1), WireW'(NumWires - 1));
    do_load(BndW'(1), IdxW'(5), WireW'(100), WireW'(200), WireW'(300));
    for (int p = 0; p < Planes; p++) do_hit(PlaneW'(p), WireW'(0), 1'b1);
    // all three planes hit
    do_query(BndW'(0), IdxW'(0));
    // nothing hit
    do_query(BndW'(NumBoundaries - 1), IdxW'(NumEntries - 1));
    do_hit(PlaneW'(0), WireW'(NumWires - 1), 1'b1);
    do_hit(PlaneW'(2), WireW'(NumWires - 1), 1'b1);
    // two planes with bad channels disabled
    do_query(BndW'(NumBoundaries - 1), IdxW'(NumEntries - 1));
    // plane out of range is ignored for hits and bad columns
    do_hit(PlaneW'(Planes), WireW'(NumWires - 1), 1'b1);
    do_bad(PlaneW'(Planes), WireW'(NumWires - 1), 1'b1);
    for (a = {1'b0, ActSpareLo}; a <= {1'b0, ActSpareHi}; a++) do_other(a[ActionW-1:0]);
    do_bad(PlaneW'(1), WireW'(NumWires - 1), 1'b1);
    // lower one hit bit with flag zero
    do_hit(PlaneW'(1), WireW'(0), 1'b0);
    do_query(BndW'(0), IdxW'(0));
    do_other(ActClear);
    do_query(BndW'(0), IdxW'(0));

    // bad channels on with factor 64: wire 4095 maps to column 63
    configure(1'b1, CfgW'(64));
    do_hit(PlaneW'(0), WireW'(NumWires - 1), 1'b1);
    do_hit(PlaneW'(2), WireW'(NumWires - 1), 1'b1);
    do_bad(PlaneW'(1), WireW'((NumWires - 1) / 64), 1'b1);
    do_query(BndW'(NumBoundaries - 1), IdxW'(NumEntries - 1));
    do_bad(PlaneW'(1), WireW'((NumWires - 1) / 64), 1'b0);
    do_query(BndW'(NumBoundaries - 1), IdxW'(NumEntries - 1));

    // random phases, each with its own config and sender idling
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin ub = 1'b1; ds = CfgW'(1);  idle_pct = 0;  end
        1: begin ub = 1'b1; ds = CfgW'(64); idle_pct = 71; end
        2: begin ub = 1'b0; ds = CfgW'(7);  idle_pct = 27; end
        // zero factor behaves as one
        3: begin ub = 1'b1; ds = CfgW'(0);  idle_pct = 0;  end
        4: begin ub = 1'b1; ds = CfgW'($urandom_range(1, 64)); idle_pct = 71; end
        default: begin ub = 1'b1; ds = CfgW'(3); idle_pct = 27; end
      endcase
      configure(ub, ds);
      target = words_sent + PhaseItems;
      while (words_sent < target) run_event();
    end

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("wire_triple_coincidence_match_top_tb OK");
    end else begin
      $display("wire_triple_coincidence_match_top_tb NOT OK");
    end
    $finish;
  end

  // hard stop if the block hangs or results go missing
  initial begin : watchdog
    #(TimeLimit);
    $display("wire_triple_coincidence_match_top_tb NOT OK");
    $finish;
  end

endmodule
